>>> rtl/core/bfga_pkg.sv
// Shared types, constants and helpers for the bond force gradient accumulator.
package bfga_pkg;

  localparam int MAX_ATOMS  = 1024;
  localparam int IDX_W      = $clog2(MAX_ATOMS);
  localparam int IN_DATA_W  = 216;
  localparam int OUT_DATA_W = 104;
  localparam int G_W        = 48;
  localparam int MA_W       = 102;
  localparam int MB_W       = 68;
  localparam int Q_W        = 48;

  localparam logic [G_W-1:0] GMAX = {1'b0, {(G_W-1){1'b1}}};
  localparam logic [G_W-1:0] GMIN = {1'b1, {(G_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_BOND = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_BOND,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [IDX_W-1:0]   idx_a;
    logic [IDX_W-1:0]   idx_b;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic [31:0]        k;
    logic signed [31:0] slip;
  } item_t;

  typedef enum logic [1:0] {
    MDU_MUL,
    MDU_SQRT,
    MDU_DIV
  } mdu_op_e;

  typedef struct packed {
    logic            start;
    mdu_op_e         op;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mdu_req_t;

  typedef struct packed {
    logic            done;
    logic            sat;
    logic [MA_W-1:0] acc;
    logic [Q_W-1:0]  res;
  } mdu_rsp_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_DIFF,
    ST_SQ_RX,
    ST_SQ_RY,
    ST_RT_R,
    ST_SQ_CX,
    ST_SQ_CY,
    ST_RT_C,
    ST_CHECK,
    ST_KE,
    ST_DEN,
    ST_NUM_X,
    ST_DIV_X,
    ST_NUM_Y,
    ST_DIV_Y,
    ST_GA_RD,
    ST_GA_WR,
    ST_GB_RD,
    ST_GB_WR,
    ST_RD
  } st_e;

  function automatic logic [G_W-1:0] sat_g(input logic signed [G_W+1:0] v);
    logic [G_W-1:0] r;
    if (v > $signed({{2{1'b0}}, GMAX})) begin
      r = GMAX;
    end else if (v < $signed({{2{1'b1}}, GMIN})) begin
      r = GMIN;
    end else begin
      r = v[G_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : v;
    return m[31:0];
  endfunction

  function automatic logic [G_W-1:0] force_of(input logic sat, input logic [Q_W-1:0] q,
                                              input logic neg);
    logic [G_W-1:0] lim;
    logic [G_W-1:0] qq;
    lim = neg ? GMAX : GMIN;
    qq  = (sat || (q > lim)) ? lim : q;
    return neg ? qq : G_W'(-qq);
  endfunction

endpackage

>>> rtl/core/bfga_front.sv
// Input side: accepts words, drops the unused mode, queues work for the back end.
module bfga_front import bfga_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           in_mode_i,
  input  logic [IN_DATA_W-1:0] in_data_i,
  input  logic                 hold_i,
  output logic                 item_valid_o,
  output item_t                item_o,
  input  logic                 item_pop_i
);

  item_t       slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  item_t       item_in;
  mode_e       mode;

  assign mode       = mode_e'(in_mode_i);
  assign in_ready_o = (cnt_q != 2'd2) && !hold_i;
  assign push       = in_valid_i && in_ready_o && (mode != MODE_NONE);

  always_comb begin
    item_in.idx_a = in_data_i[9:0];
    item_in.idx_b = in_data_i[19:10];
    item_in.pos_x = in_data_i[51:20];
    item_in.pos_y = in_data_i[83:52];
    item_in.ref_x = in_data_i[115:84];
    item_in.ref_y = in_data_i[147:116];
    item_in.k     = in_data_i[179:148];
    item_in.slip  = in_data_i[211:180];
    unique case (mode)
      MODE_LOAD: item_in.op = OP_LOAD;
      MODE_BOND: item_in.op = OP_BOND;
      default:   item_in.op = OP_READ;
    endcase
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = item_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(item_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];

endmodule

>>> rtl/core/bfga_mdu.sv
// Shared iterative unit: shift-add multiply, digit square root, bounded divide.
module bfga_mdu import bfga_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mdu_req_t req_i,
  output mdu_rsp_t rsp_o
);

  localparam logic [5:0] MUL_STEPS  = 6'd34;
  localparam logic [5:0] SQRT_STEPS = 6'd33;
  localparam logic [5:0] DIV_STEPS  = 6'd48;

  logic            busy_q;
  logic            done_q;
  logic [5:0]      cnt_q;
  mdu_op_e         op_q;
  logic [MA_W-1:0] x_q;
  logic [MB_W-1:0] y_q;
  logic [MA_W-1:0] acc_q;
  logic [Q_W-1:0]  res_q;
  logic            sat_q;

  logic [MA_W-1:0] mul_acc;
  logic [36:0]     sq_rem;
  logic [36:0]     sq_trial;
  logic [68:0]     dv_rem;
  logic            dv_ge;
  logic            init_sat;

  always_comb begin
    mul_acc  = y_q[0] ? (acc_q + x_q) : acc_q;
    sq_rem   = {acc_q[34:0], x_q[65:64]};
    sq_trial = {1'b0, res_q[33:0], 2'b01};
    dv_rem   = {acc_q[67:0], x_q[47]};
    dv_ge    = (dv_rem >= {1'b0, y_q});
    init_sat = ({14'b0, req_i.a[101:48]} >= req_i.b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (req_i.op == MDU_DIV && init_sat) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          unique case (req_i.op)
            MDU_MUL:  cnt_q <= MUL_STEPS;
            MDU_SQRT: cnt_q <= SQRT_STEPS;
            default:  cnt_q <= DIV_STEPS;
          endcase
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      x_q   <= req_i.a;
      y_q   <= req_i.b;
      res_q <= '0;
      sat_q <= (req_i.op == MDU_DIV) && init_sat;
      acc_q <= (req_i.op == MDU_DIV) ? {48'b0, req_i.a[101:48]} : '0;
    end else if (busy_q) begin
      unique case (op_q)
        MDU_MUL: begin
          acc_q <= mul_acc;
          x_q   <= {x_q[MA_W-2:0], 1'b0};
          y_q   <= {1'b0, y_q[MB_W-1:1]};
        end
        MDU_SQRT: begin
          x_q <= {x_q[MA_W-3:0], 2'b00};
          if (sq_rem >= sq_trial) begin
            acc_q <= {65'b0, 37'(sq_rem - sq_trial)};
            res_q <= {res_q[Q_W-2:0], 1'b1};
          end else begin
            acc_q <= {65'b0, sq_rem};
            res_q <= {res_q[Q_W-2:0], 1'b0};
          end
        end
        default: begin
          x_q <= {x_q[MA_W-2:0], 1'b0};
          if (dv_ge) begin
            acc_q <= {33'b0, 69'(dv_rem - {1'b0, y_q})};
            res_q <= {res_q[Q_W-2:0], 1'b1};
          end else begin
            acc_q <= {33'b0, dv_rem};
            res_q <= {res_q[Q_W-2:0], 1'b0};
          end
        end
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign rsp_o.acc  = acc_q;
  assign rsp_o.res  = res_q;

endmodule

>>> rtl/core/bfga_back.sv
// Back end: position and gradient memories, bond sequencer, result register.
module bfga_back import bfga_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  item_t          item_i,
  output logic           item_pop_o,
  output logic           hold_o,
  output mdu_req_t       mdu_req_o,
  input  mdu_rsp_t       mdu_rsp_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [G_W-1:0] out_gx_o,
  output logic [G_W-1:0] out_gy_o,
  output logic           out_flag_o
);

  st_e              state_q, state_d;
  logic             wait_q;
  logic [IDX_W-1:0] clr_idx_q;
  logic             flag_q;
  logic             out_valid_q;
  logic [G_W-1:0]   out_gx_q, out_gy_q;
  logic             out_flag_q;

  logic [63:0]      cur_mem [MAX_ATOMS];
  logic [63:0]      ref_mem [MAX_ATOMS];
  logic [95:0]      grad_mem [MAX_ATOMS];
  logic [63:0]      cur_rd_q, ref_rd_q;
  logic [95:0]      grad_rd_q;

  item_t              cur_q;
  logic [63:0]        ca_q, ra_q;
  logic signed [32:0] dcx_q, dcy_q, drx_q, dry_q;
  logic [63:0]        sq_q;
  logic [64:0]        sum_q;
  logic [32:0]        rl_q, cl_q;
  logic signed [35:0] e_q;
  logic [65:0]        ke_q;
  logic [66:0]        den_q;
  logic [97:0]        num_q;
  logic [G_W-1:0]     fx_q, fy_q;

  logic             pos_re, pos_we, grad_re, grad_we;
  logic [IDX_W-1:0] rd_addr, grad_waddr;
  logic [95:0]      grad_wdata;
  logic             mdu_state;
  logic             out_free;
  logic             degenerate;
  logic [33:0]      e_mag;
  logic             neg_x, neg_y;
  logic [G_W-1:0]   g_x, g_y;

  assign out_free   = !out_valid_q || out_ready_i;
  assign degenerate = (rl_q == '0) || (cl_q == '0);
  assign e_mag      = e_q[35] ? 34'(-e_q) : e_q[33:0];
  assign neg_x      = e_q[35] ^ dcx_q[32];
  assign neg_y      = e_q[35] ^ dcy_q[32];
  assign g_x        = grad_rd_q[47:0];
  assign g_y        = grad_rd_q[95:48];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_idx_q == IDX_W'(MAX_ATOMS - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (item_valid_i) begin
          unique case (item_i.op)
            OP_LOAD: state_d = ST_IDLE;
            OP_BOND: state_d = ST_FETCH_A;
            default: state_d = ST_RD;
          endcase
        end
      end
      ST_FETCH_A: state_d = ST_FETCH_B;
      ST_FETCH_B: state_d = ST_DIFF;
      ST_DIFF:    state_d = ST_SQ_RX;
      ST_SQ_RX:   if (mdu_rsp_i.done) state_d = ST_SQ_RY;
      ST_SQ_RY:   if (mdu_rsp_i.done) state_d = ST_RT_R;
      ST_RT_R:    if (mdu_rsp_i.done) state_d = ST_SQ_CX;
      ST_SQ_CX:   if (mdu_rsp_i.done) state_d = ST_SQ_CY;
      ST_SQ_CY:   if (mdu_rsp_i.done) state_d = ST_RT_C;
      ST_RT_C:    if (mdu_rsp_i.done) state_d = ST_CHECK;
      ST_CHECK:   state_d = degenerate ? ST_IDLE : ST_KE;
      ST_KE:      if (mdu_rsp_i.done) state_d = ST_DEN;
      ST_DEN:     if (mdu_rsp_i.done) state_d = ST_NUM_X;
      ST_NUM_X:   if (mdu_rsp_i.done) state_d = ST_DIV_X;
      ST_DIV_X:   if (mdu_rsp_i.done) state_d = ST_NUM_Y;
      ST_NUM_Y:   if (mdu_rsp_i.done) state_d = ST_DIV_Y;
      ST_DIV_Y:   if (mdu_rsp_i.done) state_d = ST_GA_RD;
      ST_GA_RD:   state_d = ST_GA_WR;
      ST_GA_WR:   state_d = ST_GB_RD;
      ST_GB_RD:   state_d = ST_GB_WR;
      ST_GB_WR:   state_d = ST_IDLE;
      ST_RD:      if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_pop_o    = 1'b0;
    pos_re        = 1'b0;
    pos_we        = 1'b0;
    grad_re       = 1'b0;
    grad_we       = 1'b0;
    rd_addr       = cur_q.idx_a;
    grad_waddr    = cur_q.idx_a;
    grad_wdata    = '0;
    mdu_state     = 1'b0;
    mdu_req_o.op  = MDU_MUL;
    mdu_req_o.a   = '0;
    mdu_req_o.b   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        grad_we    = 1'b1;
        grad_waddr = clr_idx_q;
      end
      ST_IDLE: begin
        item_pop_o = item_valid_i;
        rd_addr    = item_i.idx_a;
        grad_waddr = item_i.idx_a;
        pos_we     = item_valid_i && (item_i.op == OP_LOAD);
        grad_we    = item_valid_i && (item_i.op == OP_LOAD);
        grad_re    = item_valid_i && (item_i.op == OP_READ);
      end
      ST_FETCH_A: pos_re = 1'b1;
      ST_FETCH_B: begin
        pos_re  = 1'b1;
        rd_addr = cur_q.idx_b;
      end
      ST_SQ_RX: begin
        mdu_state   = 1'b1;
        mdu_req_o.a = {70'b0, mag33(drx_q)};
        mdu_req_o.b = {36'b0, mag33(drx_q)};
      end
      ST_SQ_RY: begin
        mdu_state   = 1'b1;
        mdu_req_o.a = {70'b0, mag33(dry_q)};
        mdu_req_o.b = {36'b0, mag33(dry_q)};
      end
      ST_SQ_CX: begin
        mdu_state   = 1'b1;
        mdu_req_o.a = {70'b0, mag33(dcx_q)};
        mdu_req_o.b = {36'b0, mag33(dcx_q)};
      end
      ST_SQ_CY: begin
        mdu_state   = 1'b1;
        mdu_req_o.a = {70'b0, mag33(dcy_q)};
        mdu_req_o.b = {36'b0, mag33(dcy_q)};
      end
      ST_RT_R, ST_RT_C: begin
        mdu_state    = 1'b1;
        mdu_req_o.op = MDU_SQRT;
        mdu_req_o.a  = {37'b0, sum_q};
      end
      ST_KE: begin
        mdu_state   = 1'b1;
        mdu_req_o.a = {68'b0, e_mag};
        mdu_req_o.b = {36'b0, cur_q.k};
      end
      ST_DEN: begin
        mdu_state   = 1'b1;
        mdu_req_o.a = {69'b0, rl_q};
        mdu_req_o.b = {35'b0, cl_q};
      end
      ST_NUM_X: begin
        mdu_state   = 1'b1;
        mdu_req_o.a = {36'b0, ke_q};
        mdu_req_o.b = {36'b0, mag33(dcx_q)};
      end
      ST_NUM_Y: begin
        mdu_state   = 1'b1;
        mdu_req_o.a = {36'b0, ke_q};
        mdu_req_o.b = {36'b0, mag33(dcy_q)};
      end
      ST_DIV_X, ST_DIV_Y: begin
        mdu_state    = 1'b1;
        mdu_req_o.op = MDU_DIV;
        mdu_req_o.a  = {4'b0, num_q};
        mdu_req_o.b  = {1'b0, den_q};
      end
      ST_GA_RD: grad_re = 1'b1;
      ST_GA_WR: begin
        grad_we    = 1'b1;
        grad_wdata = {sat_g(50'(signed'(g_y)) + 50'(signed'(fy_q))),
                      sat_g(50'(signed'(g_x)) + 50'(signed'(fx_q)))};
      end
      ST_GB_RD: begin
        grad_re = 1'b1;
        rd_addr = cur_q.idx_b;
      end
      ST_GB_WR: begin
        grad_we    = 1'b1;
        grad_waddr = cur_q.idx_b;
        grad_wdata = {sat_g(50'(signed'(g_y)) - 50'(signed'(fy_q))),
                      sat_g(50'(signed'(g_x)) - 50'(signed'(fx_q)))};
      end
      default: ;
    endcase
    mdu_req_o.start = mdu_state && !wait_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      wait_q      <= 1'b0;
      clr_idx_q   <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mdu_rsp_i.done) begin
        wait_q <= 1'b0;
      end else if (mdu_req_o.start) begin
        wait_q <= 1'b1;
      end
      if (state_q == ST_CLEAR) begin
        clr_idx_q <= clr_idx_q + IDX_W'(1);
      end
      if (state_q == ST_CHECK && degenerate) begin
        flag_q <= 1'b1;
      end
      if (state_q == ST_RD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      cur_mem[item_i.idx_a] <= {item_i.pos_y, item_i.pos_x};
      ref_mem[item_i.idx_a] <= {item_i.ref_y, item_i.ref_x};
    end
    if (pos_re) begin
      cur_rd_q <= cur_mem[rd_addr];
      ref_rd_q <= ref_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (grad_we) begin
      grad_mem[grad_waddr] <= grad_wdata;
    end
    if (grad_re) begin
      grad_rd_q <= grad_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      cur_q <= item_i;
    end
    if (state_q == ST_RD && out_free) begin
      out_gx_q   <= g_x;
      out_gy_q   <= g_y;
      out_flag_q <= flag_q;
    end
    unique case (state_q)
      ST_FETCH_B: begin
        ca_q <= cur_rd_q;
        ra_q <= ref_rd_q;
      end
      ST_DIFF: begin
        dcx_q <= $signed({cur_rd_q[31], cur_rd_q[31:0]}) - $signed({ca_q[31], ca_q[31:0]});
        dcy_q <= $signed({cur_rd_q[63], cur_rd_q[63:32]}) - $signed({ca_q[63], ca_q[63:32]});
        drx_q <= $signed({ref_rd_q[31], ref_rd_q[31:0]}) - $signed({ra_q[31], ra_q[31:0]});
        dry_q <= $signed({ref_rd_q[63], ref_rd_q[63:32]}) - $signed({ra_q[63], ra_q[63:32]});
      end
      ST_SQ_RX, ST_SQ_CX: if (mdu_rsp_i.done) sq_q <= mdu_rsp_i.acc[63:0];
      ST_SQ_RY, ST_SQ_CY: begin
        if (mdu_rsp_i.done) sum_q <= {1'b0, sq_q} + {1'b0, mdu_rsp_i.acc[63:0]};
      end
      ST_RT_R: if (mdu_rsp_i.done) rl_q <= mdu_rsp_i.res[32:0];
      ST_RT_C: if (mdu_rsp_i.done) cl_q <= mdu_rsp_i.res[32:0];
      ST_CHECK: begin
        e_q <= $signed({3'b0, cl_q}) - $signed({3'b0, rl_q})
               - $signed({{4{cur_q.slip[31]}}, cur_q.slip});
      end
      ST_KE:    if (mdu_rsp_i.done) ke_q <= mdu_rsp_i.acc[65:0];
      ST_DEN:   if (mdu_rsp_i.done) den_q <= {mdu_rsp_i.acc[65:0], 1'b0};
      ST_NUM_X, ST_NUM_Y: if (mdu_rsp_i.done) num_q <= mdu_rsp_i.acc[97:0];
      ST_DIV_X: if (mdu_rsp_i.done) fx_q <= force_of(mdu_rsp_i.sat, mdu_rsp_i.res, neg_x);
      ST_DIV_Y: if (mdu_rsp_i.done) fy_q <= force_of(mdu_rsp_i.sat, mdu_rsp_i.res, neg_y);
      default: ;
    endcase
  end

  assign hold_o      = (state_q == ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_gx_o    = out_gx_q;
  assign out_gy_o    = out_gy_q;
  assign out_flag_o  = out_flag_q;

endmodule

>>> rtl/core/bond_force_gradient_accumulator.sv
// Top level of the bond force gradient accumulator.
//
//   channel  | dir | tdata fields (low bit up)                          | tuser
//   s_axis   | in  | atom_index, neighbour_index, pos_x, pos_y, ref_x,   | mode
//            |     | ref_y, stiffness, plastic_slip, zero pad to 216     |
//   m_axis   | out | grad_x, grad_y, degenerate_seen, zero pad to 104    | -
//
// A load is written from the idle state; a read passes the gradient read register,
// then waits in ST_RD for any output stall before the output register takes it.
// A bond runs on the shared iterative unit: eight 34-step multiplies, two
// 33-step square roots and two 48-step divides; an overflowing divide skips its
// steps with a saturated result, and a zero-length bond is skipped after the roots.
// After reset a clearing pass zeroes all 1024 gradient entries; s_axis_tready_o
// stays low meanwhile. A two-word queue separates input and execution.
module bond_force_gradient_accumulator import bfga_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // atom_index, neighbour_index, pos_x, pos_y,
                                                 // ref_x, ref_y, stiffness, plastic_slip, pad
  input  logic [1:0]            s_axis_tuser_i,  // mode
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o   // grad_x, grad_y, degenerate_seen, pad
);

  item_t          item;
  logic           item_valid;
  logic           item_pop;
  logic           hold;
  mdu_req_t       mdu_req;
  mdu_rsp_t       mdu_rsp;
  logic [G_W-1:0] gx, gy;
  logic           flag;

  bfga_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_mode_i    (s_axis_tuser_i),
    .in_data_i    (s_axis_tdata_i),
    .hold_i       (hold),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  bfga_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .rsp_o  (mdu_rsp)
  );

  bfga_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .hold_o       (hold),
    .mdu_req_o    (mdu_req),
    .mdu_rsp_i    (mdu_rsp),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_gx_o     (gx),
    .out_gy_o     (gy),
    .out_flag_o   (flag)
  );

  assign m_axis_tdata_o = {7'b0, flag, gy, gx};

endmodule

>>> rtl/core/bfga_checker.sv
// Port-level checks for the accumulator, bound to the top level.
module bfga_checker import bfga_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic [1:0]            s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready_o)
    else $error("input taken during gradient clear");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_DATA_W-1:97] == '0)
    else $error("output pad bits not zero");

  a_flag_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tdata_o[96]
    |=> !m_axis_tvalid_o || m_axis_tdata_o[96])
    else $error("degenerate flag cleared");

endmodule

bind bond_force_gradient_accumulator bfga_checker u_bfga_checker (.*);
